// File: sv/compensated_pool_transfer_ledger_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the compensated pool transfer ledger
// Shared property wrappers that sample on clk and are disabled in reset.
// ----------------------------------------------------------------------------
`ifndef COMPENSATED_POOL_TRANSFER_LEDGER_MACROS_SVH
`define COMPENSATED_POOL_TRANSFER_LEDGER_MACROS_SVH

// Same-cycle implication.
`define CPTL_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cptl assertion failed");

// Next-cycle implication.
`define CPTL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cptl assertion failed");

`endif

// File: sv/cptl_pkg.sv
// ----------------------------------------------------------------------------
// cptl_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cptl_pkg;

  // Pool count must be a power of two so that index wrapping is a truncation.
  localparam int POOL_COUNT = 256;
  localparam int POOL_AW    = $clog2(POOL_COUNT);
  localparam int IDX_W      = 8;
  localparam int DBL_W      = 64;

  localparam logic [1:0] OP_LOAD = 2'd0;
  localparam logic [1:0] OP_XFER = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_SKIP   = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic CFG_COMP  = 1'b0;
  localparam logic CFG_ALLOW = 1'b1;

  typedef enum logic [2:0] {
    STEP_Y,
    STEP_T,
    STEP_D,
    STEP_C,
    STEP_PLAIN
  } step_t;

  typedef struct packed {
    logic  capture;
    logic  load_wr;
    logic  rd_dst;
    logic  lat_src;
    logic  lat_dst;
    logic  add_go;
    step_t step;
    logic  side;
    logic  wr_back;
  } cmd_t;

  typedef struct packed {
    logic is_load;
    logic is_xfer;
    logic same;
    logic reject;
    logic comp;
    logic add_done;
  } stat_t;

  function automatic logic [POOL_AW-1:0] wrap_idx(input logic [IDX_W-1:0] i);
    logic [POOL_AW+IDX_W-1:0] ext;
    ext = {{POOL_AW{1'b0}}, i};
    return ext[POOL_AW-1:0];
  endfunction

endpackage

// File: sv/cptl_ram.sv
// ----------------------------------------------------------------------------
// cptl_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cptl_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: sv/cptl_fadd.sv
// ----------------------------------------------------------------------------
// cptl_fadd
// Five-stage double-precision adder/subtractor, round to nearest even.
// ----------------------------------------------------------------------------
module cptl_fadd import cptl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             go,
  input  logic [DBL_W-1:0] a,
  input  logic [DBL_W-1:0] b,
  input  logic             sub,
  output logic             done,
  output logic [DBL_W-1:0] res
);

  localparam logic [DBL_W-1:0] QNAN_DEFAULT = 64'hFFF8_0000_0000_0000;

  // Stage 1: unpack, specials, order by magnitude.
  logic             sa, sb, nan_a, nan_b, inf_a, inf_b, a_ge;
  logic [10:0]      ea, eb, xa, xb;
  logic [52:0]      ga, gb;
  logic             spec;
  logic [DBL_W-1:0] spec_v;

  logic             s1_v_r, s1_spec_r, s1_sign_r, s1_sub_r;
  logic [DBL_W-1:0] s1_specv_r;
  logic [10:0]      s1_exp_r, s1_dif_r;
  logic [52:0]      s1_big_r, s1_sml_r;

  always_comb begin
    sa    = a[63];
    sb    = b[63] ^ sub;
    ea    = a[62:52];
    eb    = b[62:52];
    nan_a = (&ea) & (|a[51:0]);
    nan_b = (&eb) & (|b[51:0]);
    inf_a = (&ea) & ~(|a[51:0]);
    inf_b = (&eb) & ~(|b[51:0]);
    ga    = {|ea, a[51:0]};
    gb    = {|eb, b[51:0]};
    xa    = (|ea) ? ea : 11'd1;
    xb    = (|eb) ? eb : 11'd1;
    a_ge  = a[62:0] >= b[62:0];
    spec  = 1'b1;
    if (nan_a) begin
      spec_v = a | 64'h0008_0000_0000_0000;
    end else if (nan_b) begin
      spec_v = b | 64'h0008_0000_0000_0000;
    end else if (inf_a && inf_b && (sa != sb)) begin
      spec_v = QNAN_DEFAULT;
    end else if (inf_a) begin
      spec_v = a;
    end else if (inf_b) begin
      spec_v = {sb, b[62:0]};
    end else begin
      spec   = 1'b0;
      spec_v = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else begin
      s1_v_r <= go;
    end
    s1_spec_r  <= spec;
    s1_specv_r <= spec_v;
    s1_sub_r   <= sa ^ sb;
    if (a_ge) begin
      s1_sign_r <= sa;
      s1_exp_r  <= xa;
      s1_big_r  <= ga;
      s1_sml_r  <= gb;
      s1_dif_r  <= xa - xb;
    end else begin
      s1_sign_r <= sb;
      s1_exp_r  <= xb;
      s1_big_r  <= gb;
      s1_sml_r  <= ga;
      s1_dif_r  <= xb - xa;
    end
  end

  // Stage 2: align the smaller operand, collecting a sticky bit.
  logic [5:0]       dcap;
  logic [111:0]     wide;
  logic             s2_v_r, s2_spec_r, s2_sign_r, s2_sub_r;
  logic [DBL_W-1:0] s2_specv_r;
  logic [10:0]      s2_exp_r;
  logic [55:0]      s2_big_r, s2_sml_r;

  always_comb begin
    dcap = (|s1_dif_r[10:6]) ? 6'd63 : s1_dif_r[5:0];
    wide = {s1_sml_r, 3'b000, 56'd0} >> dcap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else begin
      s2_v_r <= s1_v_r;
    end
    s2_spec_r  <= s1_spec_r;
    s2_specv_r <= s1_specv_r;
    s2_sign_r  <= s1_sign_r;
    s2_sub_r   <= s1_sub_r;
    s2_exp_r   <= s1_exp_r;
    s2_big_r   <= {s1_big_r, 3'b000};
    s2_sml_r   <= {wide[111:57], wide[56] | (|wide[55:0])};
  end

  // Stage 3: magnitude add or subtract.
  logic [56:0]      sum;
  logic             s3_v_r, s3_spec_r, s3_sign_r;
  logic [DBL_W-1:0] s3_specv_r;
  logic [10:0]      s3_exp_r;
  logic [56:0]      s3_sum_r;

  always_comb begin
    if (s2_sub_r) begin
      sum = {1'b0, s2_big_r} - {1'b0, s2_sml_r};
    end else begin
      sum = {1'b0, s2_big_r} + {1'b0, s2_sml_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else begin
      s3_v_r <= s2_v_r;
    end
    s3_spec_r  <= s2_spec_r;
    s3_specv_r <= s2_specv_r;
    // An exact zero is positive unless both operands were zeros of one sign.
    s3_sign_r  <= (sum == '0) ? (s2_sign_r & ~s2_sub_r) : s2_sign_r;
    s3_exp_r   <= s2_exp_r;
    s3_sum_r   <= sum;
  end

  // Stage 4: normalize, stopping at the subnormal boundary.
  logic [5:0]       lz, sh;
  logic [10:0]      lim;
  logic [11:0]      e;
  logic [55:0]      n;
  logic             s4_v_r, s4_spec_r, s4_sign_r, s4_inf_r;
  logic [DBL_W-1:0] s4_specv_r;
  logic [10:0]      s4_ef_r;
  logic [55:0]      s4_n_r;

  always_comb begin
    lz = 6'd56;
    for (int i = 0; i < 56; i++) begin
      if (s3_sum_r[i]) begin
        lz = 6'(55 - i);
      end
    end
    lim = s3_exp_r - 11'd1;
    sh  = ({5'd0, lz} < lim) ? lz : lim[5:0];
    if (s3_sum_r[56]) begin
      n = {s3_sum_r[56:2], s3_sum_r[1] | s3_sum_r[0]};
      e = {1'b0, s3_exp_r} + 12'd1;
    end else begin
      n = s3_sum_r[55:0] << sh;
      e = {1'b0, s3_exp_r} - {6'd0, sh};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else begin
      s4_v_r <= s3_v_r;
    end
    s4_spec_r  <= s3_spec_r;
    s4_specv_r <= s3_specv_r;
    s4_sign_r  <= s3_sign_r;
    s4_inf_r   <= e[11] | (&e[10:0]);
    s4_ef_r    <= n[55] ? e[10:0] : 11'd0;
    s4_n_r     <= n;
  end

  // Stage 5: round and pack; a carry walks into the exponent field.
  logic             up;
  logic [62:0]      mag;
  logic             done_r;
  logic [DBL_W-1:0] res_r;

  always_comb begin
    up  = s4_n_r[2] & (s4_n_r[3] | s4_n_r[1] | s4_n_r[0]);
    mag = {s4_ef_r, s4_n_r[54:3]} + {62'd0, up};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      done_r <= 1'b0;
    end else begin
      done_r <= s4_v_r;
    end
    if (s4_spec_r) begin
      res_r <= s4_specv_r;
    end else if (s4_inf_r) begin
      res_r <= {s4_sign_r, 11'h7FF, 52'd0};
    end else begin
      res_r <= {s4_sign_r, mag};
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

// File: sv/cptl_dp.sv
// ----------------------------------------------------------------------------
// cptl_dp
// Datapath: pool tables, operand registers, adder and result fields.
// ----------------------------------------------------------------------------
module cptl_dp import cptl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  cmd_t             cmd,
  output stat_t            stat,
  input  logic [1:0]       in_operation,
  input  logic [IDX_W-1:0] in_source_index,
  input  logic [IDX_W-1:0] in_sink_index,
  input  logic [DBL_W-1:0] in_amount,
  input  logic             cfg_valid,
  input  logic             cfg_index,
  input  logic             cfg_data,
  output logic [1:0]       out_status,
  output logic             out_negative_seen,
  output logic [DBL_W-1:0] out_source_balance,
  output logic [DBL_W-1:0] out_sink_balance
);

  logic                  comp_r, allow_r;
  logic [1:0]            op_r;
  logic [POOL_AW-1:0]    src_r, dst_r, raddr_q_r;
  logic [DBL_W-1:0]      amt_r;
  logic                  neg_r, same_r;
  logic [DBL_W-1:0]      bal_s_r, cor_s_r, bal_d_r, cor_d_r, y_r, t_r, d_r;
  logic [POOL_COUNT-1:0] vb_r;

  logic                  in_nan, is_xfer, reject;
  logic [POOL_AW-1:0]    raddr, waddr;
  logic                  we_bal, we_cor;
  logic [DBL_W-1:0]      wd_bal, wd_cor, bal_rd, cor_rd, bal_q, cor_q;
  logic [DBL_W-1:0]      bal_x, cor_x, add_a, add_b, add_res;
  logic                  add_sub, add_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      comp_r  <= 1'b0;
      allow_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_COMP:  comp_r  <= cfg_data;
        CFG_ALLOW: allow_r <= cfg_data;
        default:   comp_r  <= comp_r;
      endcase
    end
  end

  assign in_nan  = (&in_amount[62:52]) & (|in_amount[51:0]);
  assign is_xfer = op_r == OP_XFER;
  assign reject  = ~comp_r & neg_r & ~allow_r;

  always_comb begin
    bal_x = cmd.side ? bal_d_r : bal_s_r;
    cor_x = cmd.side ? cor_d_r : cor_s_r;
    unique case (cmd.step)
      STEP_Y: begin
        add_a   = cmd.side ? amt_r : {~amt_r[63], amt_r[62:0]};
        add_b   = cor_x;
        add_sub = 1'b1;
      end
      STEP_T: begin
        add_a   = bal_x;
        add_b   = y_r;
        add_sub = 1'b0;
      end
      STEP_D: begin
        add_a   = t_r;
        add_b   = bal_x;
        add_sub = 1'b1;
      end
      STEP_C: begin
        add_a   = d_r;
        add_b   = y_r;
        add_sub = 1'b1;
      end
      default: begin
        add_a   = bal_x;
        add_b   = amt_r;
        add_sub = ~cmd.side;
      end
    endcase
  end

  cptl_fadd u_fadd (
    .clk   (clk),
    .rst_n (rst_n),
    .go    (cmd.add_go),
    .a     (add_a),
    .b     (add_b),
    .sub   (add_sub),
    .done  (add_done),
    .res   (add_res)
  );

  // Table ports. Entries never written since reset read as zero. Both tables
  // are written together, so one flag per pool covers them; a plain transfer
  // writes the latched correction back unchanged.
  always_comb begin
    raddr  = cmd.rd_dst ? dst_r : src_r;
    waddr  = (cmd.wr_back && cmd.side) ? dst_r : src_r;
    we_bal = cmd.load_wr | cmd.wr_back;
    we_cor = cmd.load_wr | cmd.wr_back;
    wd_bal = cmd.load_wr ? amt_r : t_r;
    wd_cor = cmd.load_wr ? '0 : cor_x;
    bal_q  = vb_r[raddr_q_r] ? bal_rd : '0;
    cor_q  = vb_r[raddr_q_r] ? cor_rd : '0;
  end

  cptl_ram #(.WIDTH(DBL_W), .DEPTH(POOL_COUNT)) u_bal_ram (
    .clk   (clk),
    .we    (we_bal),
    .waddr (waddr),
    .wdata (wd_bal),
    .raddr (raddr),
    .rdata (bal_rd)
  );

  cptl_ram #(.WIDTH(DBL_W), .DEPTH(POOL_COUNT)) u_cor_ram (
    .clk   (clk),
    .we    (we_cor),
    .waddr (waddr),
    .wdata (wd_cor),
    .raddr (raddr),
    .rdata (cor_rd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= '0;
    end else begin
      if (we_bal) begin
        vb_r[waddr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    raddr_q_r <= raddr;
    if (cmd.capture) begin
      op_r   <= in_operation;
      src_r  <= wrap_idx(in_source_index);
      dst_r  <= wrap_idx(in_sink_index);
      amt_r  <= in_amount;
      same_r <= wrap_idx(in_source_index) == wrap_idx(in_sink_index);
      neg_r  <= in_amount[63] & (|in_amount[62:0]) & ~in_nan;
    end
    if (cmd.load_wr) begin
      bal_s_r <= amt_r;
    end
    if (cmd.lat_src) begin
      bal_s_r <= bal_q;
      cor_s_r <= cor_q;
    end
    if (cmd.lat_dst) begin
      bal_d_r <= bal_q;
      cor_d_r <= cor_q;
    end
    if (add_done) begin
      case (cmd.step)
        STEP_Y: y_r <= add_res;
        STEP_T: t_r <= add_res;
        STEP_D: d_r <= add_res;
        STEP_C: begin
          if (cmd.side) begin
            cor_d_r <= add_res;
          end else begin
            cor_s_r <= add_res;
          end
        end
        default: t_r <= add_res;
      endcase
    end
    if (cmd.wr_back) begin
      if (cmd.side) begin
        bal_d_r <= t_r;
      end else begin
        bal_s_r <= t_r;
      end
    end
  end

  always_comb begin
    stat.is_load  = op_r == OP_LOAD;
    stat.is_xfer  = is_xfer;
    stat.same     = same_r;
    stat.reject   = reject;
    stat.comp     = comp_r;
    stat.add_done = add_done;
  end

  always_comb begin
    if (!is_xfer) begin
      out_status = ST_DONE;
    end else if (same_r) begin
      out_status = ST_SKIP;
    end else if (reject) begin
      out_status = ST_REJECT;
    end else begin
      out_status = ST_DONE;
    end
  end

  assign out_negative_seen  = is_xfer & neg_r;
  assign out_source_balance = bal_s_r;
  assign out_sink_balance   = bal_d_r;

endmodule

// File: sv/cptl_ctrl.sv
// ----------------------------------------------------------------------------
// cptl_ctrl
// Sequencer: table reads, adder steps, write-back and the result strobe.
// ----------------------------------------------------------------------------
module cptl_ctrl import cptl_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy,
  output logic  out_valid
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_LD_WR,
    S_RD_S,
    S_RD_D,
    S_LAT_D,
    S_ISSUE,
    S_WAIT,
    S_WR,
    S_OUT
  } state_t;

  state_t state_r;
  step_t  step_r;
  logic   side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= STEP_Y;
      side_r  <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_RD_S;
          end
        end
        S_RD_S: begin
          if (stat.is_load) begin
            state_r <= S_LD_WR;
          end else begin
            state_r <= S_RD_D;
          end
        end
        S_LD_WR: state_r <= S_RD_D;
        S_RD_D:  state_r <= S_LAT_D;
        S_LAT_D: begin
          side_r <= 1'b0;
          step_r <= stat.comp ? STEP_Y : STEP_PLAIN;
          if (!stat.is_xfer || stat.same || stat.reject) begin
            state_r <= S_OUT;
          end else begin
            state_r <= S_ISSUE;
          end
        end
        S_ISSUE: state_r <= S_WAIT;
        S_WAIT: begin
          if (stat.add_done) begin
            unique case (step_r)
              STEP_Y:  begin step_r <= STEP_T; state_r <= S_ISSUE; end
              STEP_T:  begin step_r <= STEP_D; state_r <= S_ISSUE; end
              STEP_D:  begin step_r <= STEP_C; state_r <= S_ISSUE; end
              default: state_r <= S_WR;
            endcase
          end
        end
        S_WR: begin
          if (side_r) begin
            state_r <= S_OUT;
          end else begin
            side_r  <= 1'b1;
            step_r  <= stat.comp ? STEP_Y : STEP_PLAIN;
            state_r <= S_ISSUE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    cmd.step    = step_r;
    cmd.side    = side_r;
    cmd.capture = (state_r == S_IDLE) & start;
    cmd.load_wr = state_r == S_LD_WR;
    cmd.rd_dst  = state_r == S_RD_D;
    cmd.lat_src = (state_r == S_RD_D) & ~stat.is_load;
    cmd.lat_dst = state_r == S_LAT_D;
    cmd.add_go  = state_r == S_ISSUE;
    cmd.wr_back = state_r == S_WR;
  end

  assign busy      = state_r != S_IDLE;
  assign out_valid = state_r == S_OUT;

endmodule

// File: sv/compensated_pool_transfer_ledger.sv
// ----------------------------------------------------------------------------
// compensated_pool_transfer_ledger
// Table of double-precision pool balances with plain or Kahan transfers.
// ----------------------------------------------------------------------------
// A command word is taken on start while busy is low: a load writes one
// pool's balance and clears its correction, a transfer debits the source
// pool and credits the sink pool, and a read reports two balances. Every
// command returns exactly one result word, shown for a single cycle with
// out_valid high; the receiver has no way to hold it off, so it must take
// the word in that cycle.
// Reads, skipped and rejected transfers pass the source read, sink read
// and latch states before the strobe; loads also pass a table write
// state. Every double addition goes one at a time through the five-stage
// adder: a plain transfer makes two and a compensated transfer eight. A
// new command may be accepted in the cycle after the strobe. The user
// must write the mode bits through the cfg port only while the block is
// idle; the block itself does not enforce this. cfg_ready is always high.
// Reset clears the mode bits and marks every pool as unwritten, so all
// balances and corrections read as zero with no clearing pass.
// ----------------------------------------------------------------------------
module compensated_pool_transfer_ledger import cptl_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [1:0]       in_operation,
  input  logic [IDX_W-1:0] in_source_index,
  input  logic [IDX_W-1:0] in_sink_index,
  input  logic [DBL_W-1:0] in_amount,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic             out_negative_seen,
  output logic [DBL_W-1:0] out_source_balance,
  output logic [DBL_W-1:0] out_sink_balance,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_index,
  input  logic             cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // Mode writes are always accepted; cfg_ready is tied high.
  assign cfg_ready = 1'b1;

  // The sequencer owns timing; the datapath owns every stored value.
  cptl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  cptl_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .in_operation       (in_operation),
    .in_source_index    (in_source_index),
    .in_sink_index      (in_sink_index),
    .in_amount          (in_amount),
    .cfg_valid          (cfg_valid),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .out_status         (out_status),
    .out_negative_seen  (out_negative_seen),
    .out_source_balance (out_source_balance),
    .out_sink_balance   (out_sink_balance)
  );

endmodule

// File: sv/cptl_checker.sv
// ----------------------------------------------------------------------------
// cptl_checker
// Port-level checks on the command and result handshake of the ledger.
// ----------------------------------------------------------------------------
`include "compensated_pool_transfer_ledger_macros.svh"

module cptl_checker import cptl_pkg::*; (
  input logic             clk,
  input logic             rst_n,
  input logic             start,
  input logic             busy,
  input logic             out_valid,
  input logic [1:0]       out_status,
  input logic             out_negative_seen
);

  `CPTL_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `CPTL_ASSERT_IMPL(a_strobe_busy, out_valid, busy)
  `CPTL_ASSERT_NEXT(a_strobe_pulse, out_valid, !out_valid)
  `CPTL_ASSERT_IMPL(a_reject_neg, out_valid && out_status == ST_REJECT, out_negative_seen)

endmodule

bind compensated_pool_transfer_ledger cptl_checker u_cptl_checker (.*);

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// Testbench for compensated_pool_transfer_ledger
// Drives load, transfer and read command words through the start/busy port
// and predicts every result word with a double-precision model of the pool
// table. Each strobed result is checked field by field against the oldest
// expected word. The mode bits are changed between phases while the block
// is idle.
// ----------------------------------------------------------------------------
module tb import cptl_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [1:0]       op;
    logic [IDX_W-1:0] src;
    logic [IDX_W-1:0] dst;
    logic [DBL_W-1:0] amt;
  } command_word_t;

  typedef struct {
    logic [1:0]       status;
    logic             neg;
    logic [DBL_W-1:0] src_bal;
    logic [DBL_W-1:0] dst_bal;
  } ledger_word_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  logic [1:0]       in_operation = OP_LOAD;
  logic [IDX_W-1:0] in_source_index = '0;
  logic [IDX_W-1:0] in_sink_index = '0;
  logic [DBL_W-1:0] in_amount = '0;
  logic             out_valid;
  logic [1:0]       out_status;
  logic             out_negative_seen;
  logic [DBL_W-1:0] out_source_balance;
  logic [DBL_W-1:0] out_sink_balance;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic             cfg_index = CFG_COMP;
  logic             cfg_data = 1'b0;

  compensated_pool_transfer_ledger u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_operation(in_operation), .in_source_index(in_source_index),
    .in_sink_index(in_sink_index), .in_amount(in_amount),
    .out_valid(out_valid), .out_status(out_status),
    .out_negative_seen(out_negative_seen),
    .out_source_balance(out_source_balance),
    .out_sink_balance(out_sink_balance),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow of the block's state: balances, Kahan corrections and mode bits.
  real  pool_bal [POOL_COUNT];
  real  pool_cor [POOL_COUNT];
  logic mode_comp = 1'b0;
  logic mode_allow = 1'b0;

  command_word_t pending_cmds[$];
  ledger_word_t  expected_words[$];
  command_word_t cur_cmd;
  int            mismatches = 0;
  int            idle_left = 0;
  bit            quiet = 1'b0;

  // One Kahan compensated accumulation into a pool.
  function automatic void kahan_accumulate(int ix, real delta);
    real y;
    real t;
    y = delta - pool_cor[ix];
    t = pool_bal[ix] + y;
    pool_cor[ix] = (t - pool_bal[ix]) - y;
    pool_bal[ix] = t;
  endfunction

  // Applies one accepted command to the shadow table and returns its result.
  function automatic ledger_word_t apply_ledger_cmd(command_word_t c);
    ledger_word_t w;
    int           s;
    int           d;
    real          v;
    s = c.src % POOL_COUNT;
    d = c.dst % POOL_COUNT;
    v = $bitstoreal(c.amt);
    w.status = ST_DONE;
    w.neg = 1'b0;
    if (c.op == OP_LOAD) begin
      pool_bal[s] = v;
      pool_cor[s] = 0.0;
    end else if (c.op == OP_XFER) begin
      // NaN and -0.0 do not compare below zero.
      w.neg = (v < 0.0);
      if (s == d) begin
        w.status = ST_SKIP;
      end else if (mode_comp) begin
        kahan_accumulate(s, -v);
        kahan_accumulate(d, v);
      end else if (w.neg && !mode_allow) begin
        w.status = ST_REJECT;
      end else begin
        pool_bal[s] = pool_bal[s] - v;
        pool_bal[d] = pool_bal[d] + v;
      end
    end
    w.src_bal = $realtobits(pool_bal[s]);
    w.dst_bal = $realtobits(pool_bal[d]);
    return w;
  endfunction

  // Command driver. A word that is up stays up until it is accepted, so start
  // gets at most one nonblocking update per edge.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_words = {expected_words, apply_ledger_cmd(cur_cmd)};
        if (!quiet && $urandom_range(0, 3) == 0) begin
          idle_left = $urandom_range(1, 5);
        end
      end
      if (!(start && busy)) begin
        if (idle_left > 0) begin
          idle_left = idle_left - 1;
          start <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          in_operation <= cur_cmd.op;
          in_source_index <= cur_cmd.src;
          in_sink_index <= cur_cmd.dst;
          in_amount <= cur_cmd.amt;
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor. The receiver cannot stall, so every strobe is a word.
  always @(posedge clk) begin
    ledger_word_t e;
    if (rst_n && out_valid) begin
      if (expected_words.size() == 0) begin
        mismatches = mismatches + 1;
        if (mismatches <= 10) begin
          $display("unexpected result word: status %0d src %h dst %h",
                   out_status, out_source_balance, out_sink_balance);
        end
      end else begin
        e = expected_words.pop_front();
        if (out_status !== e.status || out_negative_seen !== e.neg ||
            out_source_balance !== e.src_bal || out_sink_balance !== e.dst_bal) begin
          mismatches = mismatches + 1;
          if (mismatches <= 10) begin
            $display("result mismatch: exp st %0d neg %0d src %h dst %h",
                     e.status, e.neg, e.src_bal, e.dst_bal);
            $display("                 got st %0d neg %0d src %h dst %h",
                     out_status, out_negative_seen, out_source_balance,
                     out_sink_balance);
          end
        end
      end
    end
  end

  // Writes one mode bit; only called while the block is idle.
  task automatic write_mode(logic idx, logic val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_COMP) mode_comp = val;
    else mode_allow = val;
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() > 0 || start || expected_words.size() > 0) begin
      @(posedge clk);
    end
  endtask

  task automatic queue_cmd(logic [1:0] op, int s, int d, logic [DBL_W-1:0] a);
    command_word_t c;
    c.op = op;
    c.src = s[IDX_W-1:0];
    c.dst = d[IDX_W-1:0];
    c.amt = a;
    pending_cmds = {pending_cmds, c};
  endtask

  // Amounts: mostly modest values with fractions so that Kahan corrections
  // become nonzero, plus raw bit patterns and the IEEE special values.
  function automatic logic [DBL_W-1:0] pick_amount();
    real r;
    case ($urandom_range(0, 11))
      0: return {$urandom, $urandom};
      1: return 64'h7FF0_0000_0000_0000;
      2: return 64'hFFF0_0000_0000_0000;
      3: return 64'h7FF8_0000_0000_0001;
      4: return 64'h8000_0000_0000_0000;
      5: return 64'h0000_0000_0000_0001;
      default: begin
        r = $urandom_range(0, 100000) / 1024.0 + 0.1;
        if ($urandom_range(0, 4) == 0) r = r * 1.0e12;
        if ($urandom_range(0, 3) == 0) r = -r;
        return $realtobits(r);
      end
    endcase
  endfunction

  // Indices: usually a few hot pools so that balances accumulate, sometimes
  // any pool, so the top index and random high bits appear too.
  function automatic int pick_pool();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 255);
    if ($urandom_range(0, 7) == 0) return 255;
    return $urandom_range(0, 5);
  endfunction

  initial begin
    int i;
    int p;
    logic [1:0] op;
    for (i = 0; i < POOL_COUNT; i++) begin
      pool_bal[i] = 0.0;
      pool_cor[i] = 0.0;
    end
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part with reset modes: plain, negatives rejected.
    queue_cmd(OP_READ, 0, 255, 64'h0);
    queue_cmd(OP_LOAD, 0, 0, $realtobits(100.0));
    queue_cmd(OP_LOAD, 255, 0, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_cmd(OP_LOAD, 255, 0, $realtobits(1.0e16));
    queue_cmd(OP_XFER, 0, 255, $realtobits(0.1));
    queue_cmd(OP_XFER, 3, 3, $realtobits(-2.0));
    queue_cmd(OP_XFER, 0, 1, $realtobits(-5.0));
    queue_cmd(OP_XFER, 0, 1, 64'h8000_0000_0000_0000);
    queue_cmd(OP_XFER, 0, 2, 64'h7FF8_0000_0000_0000);
    queue_cmd(2'd3, 0, 1, 64'h1234);
    queue_cmd(OP_XFER, 1, 2, 64'h7FF0_0000_0000_0000);
    queue_cmd(OP_LOAD, 1, 0, 64'h0);
    queue_cmd(OP_XFER, 255, 1, 64'hFFFF_FFFF_FFFF_FFFF);
    queue_cmd(OP_READ, 255, 1, 64'h0);
    wait_drained();
    write_mode(CFG_ALLOW, 1'b1);
    queue_cmd(OP_XFER, 0, 1, $realtobits(-5.0));
    queue_cmd(OP_XFER, 4, 4, $realtobits(-1.0));
    wait_drained();
    write_mode(CFG_COMP, 1'b1);
    queue_cmd(OP_LOAD, 4, 0, $realtobits(1.0e16));
    queue_cmd(OP_XFER, 5, 4, $realtobits(1.0));
    queue_cmd(OP_XFER, 5, 4, $realtobits(1.0));
    queue_cmd(OP_XFER, 5, 4, $realtobits(-3.5));
    queue_cmd(OP_XFER, 4, 4, $realtobits(7.0));
    wait_drained();

    // Random phases over every mode setting; corrections carry across them.
    for (p = 0; p < 5; p++) begin
      write_mode(CFG_COMP, p[0]);
      write_mode(CFG_ALLOW, p[1]);
      if (p == 4) quiet = 1'b1;
      for (i = 0; i < 160; i++) begin
        case ($urandom_range(0, 9))
          0: op = OP_LOAD;
          1: op = OP_READ;
          2: op = 2'($urandom_range(0, 3));
          default: op = OP_XFER;
        endcase
        queue_cmd(op, pick_pool(), pick_pool(), pick_amount());
      end
      wait_drained();
    end

    repeat (60) @(posedge clk);
    if (mismatches == 0 && expected_words.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // The timeout leaves a wide margin over the slowest command.
  initial begin
    #3_000_000;
    $display("== FAIL ==");
    $finish;
  end

endmodule
